// ===== hdl/twc_pkg.sv =====
// Shared types, band tables and divider constants for the tuner PLL word calculator.
`timescale 1ns / 1ps

package twc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_CLOCK_MODE = 2'd0;
	localparam logic [1:0] REG_FN_MIN     = 2'd1;
	localparam logic [1:0] REG_IQ_CAL     = 2'd2;

	// Field widths.
	localparam int FREQ_W = 21;
	localparam int BW_W   = 24;
	localparam int CFG_W  = 21;
	localparam int ACC_W  = 25;
	localparam int DIVN_W = 21;
	localparam int QUO_W  = 15;

	// Clock mode codes.
	localparam logic MODE_XTAL_2000 = 1'b0;
	localparam logic MODE_XTAL_640  = 1'b1;

	// Half crystal values used for round-half-up.
	localparam logic [ACC_W-1:0] HALF_2000 = 25'd1000;
	localparam logic [ACC_W-1:0] HALF_640  = 25'd320;

	// Crystal 2000 = 16 * 125 and 640 = 128 * 5; the odd factor is divided by reciprocal.
	localparam int RECIP_SHIFT = 27;
	localparam logic [24:0] RECIP_125 = 25'd1073741;
	localparam logic [24:0] RECIP_5   = 25'd26843545;
	localparam logic [6:0] ODD_125 = 7'd125;
	localparam logic [6:0] ODD_5   = 7'd5;

	// Bandwidth requests and codes.
	localparam logic [BW_W-1:0] BW_5MHZ = 24'd5000000;
	localparam logic [BW_W-1:0] BW_6MHZ = 24'd6000000;
	localparam logic [BW_W-1:0] BW_7MHZ = 24'd7000000;
	localparam logic [2:0] BW_CODE_5 = 3'd0;
	localparam logic [2:0] BW_CODE_6 = 3'd2;
	localparam logic [2:0] BW_CODE_7 = 3'd4;
	localparam logic [2:0] BW_CODE_8 = 3'd6;

	localparam logic [7:0] BAND_CTRL_BASE = 8'ha0;
	localparam logic [7:0] IQ_NEG_LIMIT   = 8'h20;
	localparam logic [15:0] IQ_NEG_BASE   = 16'h0040;

	// LNA band edges: band k+1 covers (edge k, edge k+1].
	localparam logic [FREQ_W-1:0] LNA_EDGE [8] = '{
		21'd440000, 21'd484000, 21'd533000, 21'd587000,
		21'd645000, 21'd710000, 21'd782000, 21'd860000
	};
	localparam logic [FREQ_W-1:0] VHF_LOW   = 21'd51000;
	localparam logic [FREQ_W-1:0] LBAND_LO0 = 21'd1450000;
	localparam logic [FREQ_W-1:0] LBAND_HI0 = 21'd1492000;
	localparam logic [FREQ_W-1:0] LBAND_LO1 = 21'd1660000;
	localparam logic [FREQ_W-1:0] LBAND_HI1 = 21'd1685000;

	// Divider band edges: band k covers (edge k, edge k+1].
	localparam logic [FREQ_W-1:0] DIV_EDGE [7] = '{
		21'd53000, 21'd74000, 21'd111000, 21'd148000,
		21'd222000, 21'd296000, 21'd445000
	};
	localparam logic [5:0] DIV_VALUE [6] = '{6'd48, 6'd32, 6'd24, 6'd16, 6'd12, 6'd8};
	localparam logic [FREQ_W-1:0] DIV4_TOP  = 21'd950000;
	localparam logic [FREQ_W-1:0] DIV2_LOW  = 21'd1450000;
	localparam logic [FREQ_W-1:0] DIV2_TOP  = 21'd1680000;

	// Band decision for one item.
	typedef struct packed {
		logic       ok;
		logic       lband;
		logic [2:0] lna;
		logic [2:0] bw;
		logic [5:0] ndiv;
		logic [2:0] idx;
	} twc_band_t;

endpackage

// ===== hdl/twc_band_sel.sv =====
// Band, divider and bandwidth code selection from the requested frequency.
`timescale 1ns / 1ps

module twc_band_sel (
	input  logic [twc_pkg::FREQ_W-1:0] frequency_khz,
	input  logic [twc_pkg::BW_W-1:0]   chan_bw_hz,
	input  logic [twc_pkg::CFG_W-1:0]  fn_min_khz,
	output twc_pkg::twc_band_t         band
);
	import twc_pkg::*;

	logic lna_ok;
	logic div_ok;
	logic lband;
	logic [2:0] lna;
	logic [5:0] ndiv;
	logic [2:0] idx;

	// LNA band lookup; the ranges do not overlap.
	always_comb begin
		lna_ok = 1'b0;
		lband  = 1'b0;
		lna    = 3'd0;
		if (frequency_khz >= VHF_LOW && frequency_khz <= LNA_EDGE[0]) begin
			lna_ok = 1'b1;
		end
		for (int k = 0; k < 7; k++) begin
			if (frequency_khz > LNA_EDGE[k] && frequency_khz <= LNA_EDGE[k+1]) begin
				lna_ok = 1'b1;
				lband  = 1'b1;
				lna    = 3'(k + 1);
			end
		end
		if (frequency_khz > LBAND_LO0 && frequency_khz <= LBAND_HI0) begin
			lna_ok = 1'b1;
			lband  = 1'b1;
			lna    = 3'd0;
		end
		if (frequency_khz > LBAND_LO1 && frequency_khz <= LBAND_HI1) begin
			lna_ok = 1'b1;
			lband  = 1'b1;
			lna    = 3'd1;
		end
	end

	// Divider band lookup; the fixed bands win over the configured split.
	always_comb begin
		div_ok = 1'b0;
		ndiv   = 6'd0;
		idx    = 3'd0;
		for (int k = 0; k < 6; k++) begin
			if (frequency_khz > DIV_EDGE[k] && frequency_khz <= DIV_EDGE[k+1]) begin
				div_ok = 1'b1;
				ndiv   = DIV_VALUE[k];
				idx    = 3'(k);
			end
		end
		if (!div_ok) begin
			if (frequency_khz > DIV_EDGE[6] && frequency_khz <= fn_min_khz) begin
				div_ok = 1'b1;
				ndiv   = 6'd6;
				idx    = 3'd6;
			end else if (frequency_khz > fn_min_khz && frequency_khz <= DIV4_TOP) begin
				div_ok = 1'b1;
				ndiv   = 6'd4;
				idx    = 3'd7;
			end else if (frequency_khz > DIV2_LOW && frequency_khz <= DIV2_TOP) begin
				div_ok = 1'b1;
				ndiv   = 6'd2;
				idx    = 3'd0;
			end
		end
	end

	// Pack the decision; unknown bandwidths take the 8 MHz code.
	always_comb begin
		band.ok    = lna_ok && div_ok;
		band.lband = lband;
		band.lna   = lna;
		band.ndiv  = ndiv;
		band.idx   = idx;
		if (chan_bw_hz == BW_5MHZ) begin
			band.bw = BW_CODE_5;
		end else if (chan_bw_hz == BW_6MHZ) begin
			band.bw = BW_CODE_6;
		end else if (chan_bw_hz == BW_7MHZ) begin
			band.bw = BW_CODE_7;
		end else begin
			band.bw = BW_CODE_8;
		end
	end

endmodule

// ===== hdl/twc_round_div.sv =====
// Two-stage division by the crystal value through a reciprocal and one correction step.
`timescale 1ns / 1ps

module twc_round_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       mode,
	input  logic [twc_pkg::ACC_W-1:0]  acc,
	output logic [twc_pkg::QUO_W-1:0]  quo_s4
);
	import twc_pkg::*;

	logic [DIVN_W-1:0] num_c;
	logic [24:0]       recip_c;
	logic [45:0]       prod_c;
	logic [DIVN_W-1:0] num_s3;
	logic [QUO_W-1:0]  est_s3;
	logic              mode_s3;
	logic [6:0]        odd_c;
	logic [21:0]       back_c;
	logic [21:0]       rem_c;

	// Strip the power-of-two factor and pick the reciprocal of the odd factor.
	always_comb begin
		if (mode == MODE_XTAL_2000) begin
			num_c   = DIVN_W'(acc >> 4);
			recip_c = RECIP_125;
		end else begin
			num_c   = DIVN_W'(acc >> 7);
			recip_c = RECIP_5;
		end
		prod_c = {25'd0, num_c} * {21'd0, recip_c};
	end

	// Stage 3: quotient estimate, low by at most one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_s3 <= MODE_XTAL_640;
		end else if (en) begin
			mode_s3 <= mode;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= num_c;
			est_s3 <= prod_c[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
		end
	end

	// Remainder check and increment.
	always_comb begin
		odd_c  = (mode_s3 == MODE_XTAL_2000) ? ODD_125 : ODD_5;
		back_c = {7'd0, est_s3} * {15'd0, odd_c};
		rem_c  = {1'd0, num_s3} - back_c;
	end

	// Stage 4: corrected quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s4 <= est_s3 + QUO_W'(rem_c >= {15'd0, odd_c});
		end
	end

endmodule

// ===== hdl/tuner_pll_word_calc_core.sv =====
// Top level of the tuner PLL word calculator: configuration, pipeline and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  cfg     | cfg_we               | cfg_index, cfg_data
//  in      | in_valid / in_ready  | frequency_khz, chan_bw_hz
//  out     | out_valid / out_ready| valid_res, lna_index, bw_code, band_ctrl,
//          |                      | high_word, low_word
//
// Five register stages: band select, product and IQ offset, reciprocal multiply,
// quotient correction, word assembly. One item enters per cycle unless the pipeline holds.
// When the result register is full and not taken, the whole pipeline holds in place.
// Reset clears the valid bits and sets the configuration to its reset values.
`timescale 1ns / 1ps

module tuner_pll_word_calc_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [twc_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [twc_pkg::FREQ_W-1:0] frequency_khz,
	input  logic [twc_pkg::BW_W-1:0]   chan_bw_hz,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       valid_res,
	output logic [2:0]                 lna_index,
	output logic [2:0]                 bw_code,
	output logic [7:0]                 band_ctrl,
	output logic [15:0]                high_word,
	output logic [15:0]                low_word
);
	import twc_pkg::*;

	logic              clock_mode_q;
	logic [CFG_W-1:0]  fn_min_khz_q;
	logic [7:0]        iq_cal_value_q;

	logic              en;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	twc_band_t         band_c;
	twc_band_t         band_s1, band_s2, band_s3, band_s4;
	logic [FREQ_W-1:0] freq_s1;
	logic              mode_s2;
	logic [ACC_W-1:0]  acc_s2;
	logic [15:0]       off_s2, off_s3, off_s4;
	logic [QUO_W-1:0]  quo_s4;

	logic [26:0]       prod_c;
	logic [28:0]       sum_c;
	logic [13:0]       iq_m_c;
	logic [15:0]       iq_n_c;
	logic [19:0]       iq_x9_c;
	logic [15:0]       off_c;
	logic [15:0]       word_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mode_q   <= MODE_XTAL_640;
			fn_min_khz_q   <= '0;
			iq_cal_value_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOCK_MODE: clock_mode_q   <= cfg_data[0];
				REG_FN_MIN:     fn_min_khz_q   <= cfg_data;
				REG_IQ_CAL:     iq_cal_value_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the result register is free or being taken.
	assign en       = !v_s5 || out_ready;
	assign in_ready = en;

	// Valid bits travel with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	twc_band_sel u_band_sel (
		.frequency_khz (frequency_khz),
		.chan_bw_hz    (chan_bw_hz),
		.fn_min_khz    (fn_min_khz_q),
		.band          (band_c)
	);

	// Stage 1: band decision.
	always_ff @(posedge clk) begin
		if (en) begin
			band_s1 <= band_c;
			freq_s1 <= frequency_khz;
		end
	end

	// Scaled product plus half the crystal, for round-half-up.
	always_comb begin
		prod_c = {6'd0, freq_s1} * {21'd0, band_s1.ndiv};
		if (clock_mode_q == MODE_XTAL_2000) begin
			sum_c = {2'd0, prod_c} + {1'd0, prod_c, 1'b0} + {4'd0, HALF_2000};
		end else begin
			sum_c = {2'd0, prod_c} + {4'd0, HALF_640};
		end
	end

	// IQ calibration offset, negated form for large calibration bytes.
	always_comb begin
		iq_m_c = {6'd0, iq_cal_value_q} * {8'd0, band_s1.ndiv};
		if (iq_cal_value_q < IQ_NEG_LIMIT) begin
			iq_n_c = {2'd0, iq_m_c};
		end else begin
			iq_n_c = IQ_NEG_BASE - {2'd0, iq_m_c};
		end
		iq_x9_c = {4'd0, iq_n_c} * 20'd9;
		if (clock_mode_q == MODE_XTAL_2000) begin
			off_c = {1'b0, iq_x9_c[19:5]};
		end else begin
			off_c = {1'b0, iq_n_c[15:1]};
		end
		if (iq_cal_value_q >= IQ_NEG_LIMIT) begin
			off_c = ~off_c;
		end
	end

	// Stage 2: dividend and offset.
	always_ff @(posedge clk) begin
		if (en) begin
			band_s2 <= band_s1;
			acc_s2  <= sum_c[ACC_W-1:0];
			off_s2  <= off_c;
			mode_s2 <= clock_mode_q;
		end
	end

	// Stages 3 and 4: division by the crystal.
	twc_round_div u_round_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.mode   (mode_s2),
		.acc    (acc_s2),
		.quo_s4 (quo_s4)
	);

	// Side data follows the divider.
	always_ff @(posedge clk) begin
		if (en) begin
			band_s3 <= band_s2;
			off_s3  <= off_s2;
			band_s4 <= band_s3;
			off_s4  <= off_s3;
		end
	end

	// Word assembly with the divider index at bit 13.
	assign word_c = {1'b0, quo_s4} + {band_s4.idx, 13'd0};

	// Stage 5: result register; an unsupported frequency gives all zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			valid_res <= band_s4.ok;
			if (band_s4.ok) begin
				lna_index <= band_s4.lna;
				bw_code   <= band_s4.bw;
				band_ctrl <= BAND_CTRL_BASE | {4'd0, band_s4.lband, 3'd0};
				low_word  <= word_c;
				high_word <= word_c + off_s4;
			end else begin
				lna_index <= '0;
				bw_code   <= '0;
				band_ctrl <= '0;
				low_word  <= '0;
				high_word <= '0;
			end
		end
	end

	assign out_valid = v_s5;

`ifndef SYNTHESIS
	// A rejected request shows no register values.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> high_word == 16'd0 && low_word == 16'd0 &&
			band_ctrl == 8'd0 && lna_index == 3'd0 && bw_code == 3'd0)
		else $error("rejected request carries nonzero fields");

	// A supported request has the fixed control bits and an even bandwidth code.
	a_valid_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> band_ctrl[7:4] == 4'ha && band_ctrl[2:0] == 3'd0 &&
			!bw_code[0])
		else $error("malformed control byte or bandwidth code");

	// An accepted item enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item lost at stage one");

	// A held result keeps its words while the pipeline waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5 && $stable(low_word) && $stable(high_word) && $stable(v_s4))
		else $error("pipeline moved during a stall");
`endif

endmodule
